[rtl/mebs_pkg.sv]
package mebs_pkg;

   localparam int TRACKS = 16;
   localparam int EVENTS_PER_TRACK = 1024;
   localparam int TRACK_W = $clog2(TRACKS);
   localparam int INDEX_W = $clog2(EVENTS_PER_TRACK);
   localparam int ADDR_W = TRACK_W + INDEX_W;
   localparam int LEN_W = INDEX_W + 1;
   localparam int TOTAL_W = TRACK_W + 1;
   localparam int TICK_W = 32;
   localparam int MSG_W = 24;
   localparam int SAMP_W = 14;
   localparam int OFF_W = 13;
   localparam int SPT_W = 32;
   localparam int CNT_W = 6;
   localparam logic [SAMP_W-1:0] MAX_SAMPLES = 14'd8192;
   localparam logic [CNT_W-1:0] MAX_EVENTS = 6'd63;

   // request opcodes
   localparam logic [2:0] OP_CLEAR = 3'd0;
   localparam logic [2:0] OP_LOAD = 3'd1;
   localparam logic [2:0] OP_START = 3'd2;
   localparam logic [2:0] OP_STOP = 3'd3;
   localparam logic [2:0] OP_PROCESS = 3'd4;

   // result kinds
   localparam logic KIND_EVENT = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic [2:0] opcode;
      logic [3:0] track;
      logic [9:0] event_index;
      logic [31:0] event_tick;
      logic [23:0] event_message;
      logic last_of_track;
      logic [13:0] num_samples;
      logic [31:0] samples_per_tick;
   } req_type;

   typedef struct packed {
      logic kind;
      logic [3:0] out_track;
      logic [23:0] out_message;
      logic [12:0] sample_offset;
      logic is_playing;
      logic [31:0] position;
      logic overflow;
      logic is_last;
   } rsp_type;

endpackage

[rtl/midi_event_block_scheduler.sv]
// MIDI event block scheduler.
// Requests arrive on req_valid/req_data and are taken when req_stall is low.
// Load requests write one event (tick, message) into the event memory; a load
// marked last of track sets that track's length and rescans all tracks for the
// largest last-event tick, one track at a time. Clear, start and stop act at once.
// A process request, when playback is running and a track end is loaded, divides
// the block length by samples_per_tick bit-serially, then walks each track's
// events through one memory read port: each event looked at is read and checked,
// and one that lands in the block is scaled to a sample offset and emitted.
// Every request ends in a status result (kind 1, is_last 1), preceded by up to
// 63 event results for a process request. Results leave through one output
// register on rsp_valid/rsp_data; while rsp_stall is high the result holds and
// the scan waits. req_stall stays high until the status result is loaded into
// the output register. Reset (synchronous) clears lengths, playhead, playback and
// the loop flag; the event memory is not cleared and no clearing pass is needed.
module midi_event_block_scheduler (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input mebs_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output mebs_pkg::rsp_type rsp_data,
   input logic csr_write_en,
   input logic csr_write_data
);
   import mebs_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE = 12'b0000_0000_0001,
      S_ERD  = 12'b0000_0000_0010,
      S_ECMP = 12'b0000_0000_0100,
      S_DIV  = 12'b0000_0000_1000,
      S_TRK  = 12'b0000_0001_0000,
      S_RD   = 12'b0000_0010_0000,
      S_CHK  = 12'b0000_0100_0000,
      S_MUL  = 12'b0000_1000_0000,
      S_OFF  = 12'b0001_0000_0000,
      S_EMIT = 12'b0010_0000_0000,
      S_FIN  = 12'b0100_0000_0000,
      S_STAT = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [LEN_W-1:0] len_ff [TRACKS];
   logic [LEN_W-1:0] len_in [TRACKS];
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TICK_W-1:0] end_tick_ff, end_tick_in;
   logic [TICK_W-1:0] playhead_ff, playhead_in;
   logic running_ff, running_in;
   logic loop_ff, loop_in;

   logic [TOTAL_W-1:0] trk_ff, trk_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic ovf_ff, ovf_in;
   logic [SAMP_W-1:0] nsamp_ff, nsamp_in;
   logic [SPT_W-1:0] spt_ff, spt_in;
   logic [32:0] quo_ff, quo_in;
   logic [34:0] rem_ff, rem_in;
   logic [33:0] end_ff, end_in;
   logic [63:0] prod_ff, prod_in;
   logic [TICK_W-1:0] tk_ff, tk_in;
   logic [MSG_W-1:0] msg_ff, msg_in;
   logic [47:0] off_ff, off_in;

   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // event memory: {tick, message}
   logic [TICK_W+MSG_W-1:0] mem [TRACKS*EVENTS_PER_TRACK];
   logic [TICK_W+MSG_W-1:0] rd_ff;
   logic mem_we;
   logic [ADDR_W-1:0] wr_addr, rd_addr;

   logic accept;
   logic out_free;
   logic [LEN_W-1:0] cur_len;
   logic [LEN_W-1:0] idx_next;
   logic [34:0] rem_shift;
   logic [33:0] div_sor;
   logic [34:0] np_sum;
   logic [63:0] off_sum;

   assign accept = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assign cur_len = len_ff[trk_ff[TRACK_W-1:0]];
   assign idx_next = idx_ff + 1'b1;
   assign wr_addr = {req_data.track, req_data.event_index};
   assign mem_we = accept && (req_data.opcode == OP_LOAD);
   assign rd_addr = (state_ff == S_ERD) ?
      {trk_ff[TRACK_W-1:0], INDEX_W'(cur_len - 1'b1)} :
      {trk_ff[TRACK_W-1:0], idx_ff[INDEX_W-1:0]};

   // divider step: remainder against 2*spt
   assign div_sor = {1'b0, spt_ff, 1'b0};
   assign rem_shift = {rem_ff[33:0], quo_ff[32]};
   assign np_sum = {3'b0, playhead_ff} + {2'b0, quo_ff};
   assign off_sum = prod_ff + 64'd32768;

   // memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= {req_data.event_tick, req_data.event_message};
      end
      rd_ff <= mem[rd_addr];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      len_in = len_ff;
      total_in = total_ff;
      end_tick_in = end_tick_ff;
      playhead_in = playhead_ff;
      running_in = running_ff;
      loop_in = csr_write_en ? csr_write_data : loop_ff;
      trk_in = trk_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      nsamp_in = nsamp_ff;
      spt_in = spt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      end_in = end_ff;
      prod_in = prod_ff;
      tk_in = tk_ff;
      msg_in = msg_ff;
      off_in = off_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cnt_in = '0;
               ovf_in = 1'b0;
               trk_in = '0;
               state_in = S_STAT;
               unique case (req_data.opcode)
                  OP_CLEAR: begin
                     for (int t = 0; t < TRACKS; t++) begin
                        len_in[t] = '0;
                     end
                     total_in = '0;
                     end_tick_in = '0;
                     playhead_in = '0;
                     running_in = 1'b0;
                  end
                  OP_LOAD: begin
                     if (req_data.last_of_track) begin
                        len_in[req_data.track] = LEN_W'(req_data.event_index) + 1'b1;
                        if (total_ff < TOTAL_W'(req_data.track) + 1'b1) begin
                           total_in = TOTAL_W'(req_data.track) + 1'b1;
                        end
                        end_tick_in = '0;
                        state_in = S_ERD;
                     end
                  end
                  OP_START: begin
                     running_in = 1'b1;
                     playhead_in = '0;
                  end
                  OP_STOP: begin
                     running_in = 1'b0;
                  end
                  OP_PROCESS: begin
                     if (running_ff && total_ff != '0) begin
                        nsamp_in = (req_data.num_samples > MAX_SAMPLES) ?
                           MAX_SAMPLES : req_data.num_samples;
                        spt_in = (req_data.samples_per_tick == '0) ?
                           SPT_W'(1) : req_data.samples_per_tick;
                        // numerator n*2^17 + spt, fed MSB first
                        quo_in = {2'b0, nsamp_in, 17'b0} + {1'b0, spt_in};
                        rem_in = '0;
                        idx_in = '0;
                        state_in = S_DIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // end-tick rescan: read, then compare, one track at a time
         S_ERD: begin
            state_in = S_ECMP;
         end
         S_ECMP: begin
            if (cur_len != '0 && rd_ff[TICK_W+MSG_W-1:MSG_W] > end_tick_ff) begin
               end_tick_in = rd_ff[TICK_W+MSG_W-1:MSG_W];
            end
            if (trk_ff == TOTAL_W'(TRACKS - 1)) begin
               trk_in = '0;
               state_in = S_STAT;
            end else begin
               trk_in = trk_ff + 1'b1;
               state_in = S_ERD;
            end
         end
         // restoring division, one quotient bit per cycle
         S_DIV: begin
            if (rem_shift >= {1'b0, div_sor}) begin
               rem_in = rem_shift - {1'b0, div_sor};
               quo_in = {quo_ff[31:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               quo_in = {quo_ff[31:0], 1'b0};
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LEN_W'(32)) begin
               idx_in = '0;
               end_in = {2'b0, playhead_ff} + {1'b0, quo_in};
               state_in = S_TRK;
            end
         end
         // pick the next track with events
         S_TRK: begin
            idx_in = '0;
            if (trk_ff >= total_ff) begin
               state_in = S_FIN;
            end else if (cur_len == '0) begin
               trk_in = trk_ff + 1'b1;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         // window check on the event tick
         S_CHK: begin
            tk_in = rd_ff[TICK_W+MSG_W-1:MSG_W];
            msg_in = rd_ff[MSG_W-1:0];
            if ({2'b0, tk_in} >= end_ff) begin
               trk_in = trk_ff + 1'b1;
               state_in = S_TRK;
            end else if (tk_in >= playhead_ff) begin
               state_in = S_MUL;
            end else if (idx_next == cur_len) begin
               trk_in = trk_ff + 1'b1;
               state_in = S_TRK;
            end else begin
               idx_in = idx_next;
               state_in = S_RD;
            end
         end
         S_MUL: begin
            prod_in = (tk_ff - playhead_ff) * spt_ff;
            state_in = S_OFF;
         end
         S_OFF: begin
            off_in = off_sum[63:16];
            state_in = S_EMIT;
         end
         // emit or drop, then move to the next event
         S_EMIT: begin
            if (off_ff[47:SAMP_W] != '0 || off_ff[SAMP_W-1:0] >= nsamp_ff) begin
               state_in = S_FIN;
            end else if (cnt_ff == MAX_EVENTS) begin
               ovf_in = 1'b1;
               state_in = S_FIN;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               rsp_in.kind = KIND_EVENT;
               rsp_in.out_track = trk_ff[TRACK_W-1:0];
               rsp_in.out_message = msg_ff;
               rsp_in.sample_offset = off_ff[OFF_W-1:0];
               cnt_in = cnt_ff + 1'b1;
               state_in = S_FIN;
            end
            // advance the scan unless still waiting on the output
            if (state_in == S_FIN) begin
               if (idx_next == cur_len) begin
                  trk_in = trk_ff + 1'b1;
                  state_in = S_TRK;
               end else begin
                  idx_in = idx_next;
                  state_in = S_RD;
               end
            end
         end
         // playhead update and end check
         S_FIN: begin
            playhead_in = (np_sum[34:32] != '0) ? '1 : np_sum[31:0];
            if (playhead_in >= end_tick_ff) begin
               if (loop_ff) begin
                  playhead_in = '0;
               end else begin
                  running_in = 1'b0;
               end
            end
            state_in = S_STAT;
         end
         S_STAT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               rsp_in.kind = KIND_STATUS;
               rsp_in.is_playing = running_ff;
               rsp_in.position = playhead_ff;
               rsp_in.overflow = ovf_ff;
               rsp_in.is_last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int t = 0; t < TRACKS; t++) begin
            len_ff[t] <= '0;
         end
         total_ff <= '0;
         end_tick_ff <= '0;
         playhead_ff <= '0;
         running_ff <= 1'b0;
         loop_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         total_ff <= total_in;
         end_tick_ff <= end_tick_in;
         playhead_ff <= playhead_in;
         running_ff <= running_in;
         loop_ff <= loop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      trk_ff <= trk_in;
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      ovf_ff <= ovf_in;
      nsamp_ff <= nsamp_in;
      spt_ff <= spt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      end_ff <= end_in;
      prod_ff <= prod_in;
      tk_ff <= tk_in;
      msg_ff <= msg_in;
      off_ff <= off_in;
      rsp_ff <= rsp_in;
   end

endmodule
